/* rtl/pidd_pkg.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative package
// Shared widths, constants, command and status types and the saturating
// arithmetic helpers of the PID controller with filtered derivative.
// ----------------------------------------------------------------------------
package pidd_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int GAIN_WIDTH   = DATA_WIDTH - 1;
    localparam int BLEND_WIDTH  = 17;
    localparam int BLEND_SHIFT  = 16;
    localparam int BLEND_ONE    = 1 << BLEND_SHIFT;
    localparam int MODE_WIDTH   = 2;
    localparam int PROD_W       = 2 * DATA_WIDTH;
    localparam int SUM_W        = DATA_WIDTH + 3;
    localparam int WRAP_W       = DATA_WIDTH + 6;
    localparam int WRAP_STEPS   = 10;
    localparam int STEP_W       = $clog2(WRAP_STEPS);
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 5;
    localparam int CFG_IDX_W    = 3;

    localparam int    SCALE_003 = ((3 << FRAC_BITS) + 50) / 100;
    localparam longint HALF_TURN = longint'(180) << FRAC_BITS;
    localparam longint FULL_TURN = longint'(360) << FRAC_BITS;

    localparam logic [WRAP_W-1:0] FULL_WRAP = WRAP_W'(FULL_TURN);
    localparam logic [WRAP_W-1:0] HALF_WRAP = WRAP_W'(HALF_TURN);
    localparam logic [WRAP_W-1:0] WRAP_BIAS = HALF_WRAP + (FULL_WRAP << (WRAP_STEPS - 1));

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [GAIN_WIDTH-1:0]        gain_t;
    typedef logic [BLEND_WIDTH-1:0]       blend_t;
    typedef logic [MODE_WIDTH-1:0]        mode_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      wide_t;

    localparam data_t DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam mode_t MODE_PLAIN    = 2'd0;
    localparam mode_t MODE_POSITION = 2'd1;
    localparam mode_t MODE_ANGLE    = 2'd2;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 3'd5;

    typedef struct packed {
        gain_t  gain_p;
        gain_t  gain_i;
        gain_t  gain_d;
        blend_t blend_factor;
        gain_t  integral_limit;
        mode_t  loop_mode;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_OFFSET,
        MUL_P,
        MUL_I,
        MUL_DNEW,
        MUL_DOLD,
        MUL_D
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_OFF,
        ST_ERR,
        ST_WRAP,
        ST_WRAP_DONE,
        ST_ACC,
        ST_MUL_I,
        ST_MUL_DN,
        ST_MUL_DO,
        ST_BLEND,
        ST_MUL_D,
        ST_DTERM,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic              load;
        logic              clear;
        mul_sel_t          mul_sel;
        logic              wr_err;
        logic              wrap_step;
        logic [STEP_W-1:0] wrap_k;
        logic              wrap_done;
        logic              wr_acc;
        logic              wr_p;
        logic              wr_i;
        logic              wr_ba;
        logic              wr_blend;
        logic              wr_d;
        logic              wr_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic angle;
        logic out_busy;
    } dp_status_t;

    function automatic wide_t ext_wide(input data_t x);
        return {{(SUM_W-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
    endfunction

    function automatic data_t sat_wide(input wide_t x);
        logic [SUM_W-DATA_WIDTH:0] hi;
        hi = x[SUM_W-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi)) begin
            return x[DATA_WIDTH-1:0];
        end
        return x[SUM_W-1] ? DMIN : DMAX;
    endfunction

    // Floor of the product scaled down, saturated to the data width.
    function automatic data_t shift_sat(input prod_t p, input logic blend);
        prod_t                          s;
        logic [PROD_W-DATA_WIDTH:0]     hi;
        s  = blend ? (p >>> BLEND_SHIFT) : (p >>> FRAC_BITS);
        hi = s[PROD_W-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi)) begin
            return s[DATA_WIDTH-1:0];
        end
        return s[PROD_W-1] ? DMIN : DMAX;
    endfunction

endpackage

/* rtl/pidd_if.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative channel interfaces
// Valid/ready channels for step beats and result beats.
// ----------------------------------------------------------------------------
interface pidd_in_if;
    import pidd_pkg::*;

    logic  valid;
    logic  ready;
    logic  cmd;
    data_t target;
    data_t measured;
    data_t target_offset;

    modport source (output valid, output cmd, output target, output measured,
                    output target_offset, input ready);
    modport sink (input valid, input cmd, input target, input measured,
                  input target_offset, output ready);
endinterface

interface pidd_out_if;
    import pidd_pkg::*;

    logic  valid;
    logic  ready;
    data_t drive;
    data_t p_term;
    data_t i_term;
    data_t d_term;

    modport source (output valid, output drive, output p_term, output i_term,
                    output d_term, input ready);
    modport sink (input valid, input drive, input p_term, input i_term,
                  input d_term, output ready);
endinterface

/* rtl/pidd_cfg.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative register file
// APB-style configuration registers for gains, blend, limit and loop mode.
// ----------------------------------------------------------------------------
module pidd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidd_pkg::APB_AW-1:0]  paddr,
    input  logic [pidd_pkg::APB_DW-1:0]  pwdata,
    output logic [pidd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output pidd_pkg::cfg_t               cfg
);
    import pidd_pkg::*;

    gain_t                gain_p_reg;
    gain_t                gain_i_reg;
    gain_t                gain_d_reg;
    blend_t               blend_reg;
    gain_t                limit_reg;
    mode_t                mode_reg;
    logic [CFG_IDX_W-1:0] index;
    logic                 wr_en;

    assign index  = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            blend_reg  <= BLEND_WIDTH'(BLEND_ONE / 2);
            limit_reg  <= '1;
            mode_reg   <= MODE_PLAIN;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_GAIN_P:    gain_p_reg <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_I:    gain_i_reg <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_D:    gain_d_reg <= pwdata[GAIN_WIDTH-1:0];
                REG_BLEND:     blend_reg  <= pwdata[BLEND_WIDTH-1:0];
                REG_INT_LIMIT: limit_reg  <= pwdata[GAIN_WIDTH-1:0];
                REG_LOOP_MODE: mode_reg   <= pwdata[MODE_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_GAIN_P:    prdata = APB_DW'(gain_p_reg);
            REG_GAIN_I:    prdata = APB_DW'(gain_i_reg);
            REG_GAIN_D:    prdata = APB_DW'(gain_d_reg);
            REG_BLEND:     prdata = APB_DW'(blend_reg);
            REG_INT_LIMIT: prdata = APB_DW'(limit_reg);
            REG_LOOP_MODE: prdata = APB_DW'(mode_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.gain_p         = gain_p_reg;
    assign cfg.gain_i         = gain_i_reg;
    assign cfg.gain_d         = gain_d_reg;
    assign cfg.blend_factor   = blend_reg;
    assign cfg.integral_limit = limit_reg;
    assign cfg.loop_mode      = mode_reg;

endmodule

/* rtl/pidd_ctrl.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative controller
// Sequences the shared multiplier, the angle wrap loop and the result write.
// ----------------------------------------------------------------------------
module pidd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_cmd,
    output logic                   in_ready,
    input  pidd_pkg::dp_status_t   sts,
    output pidd_pkg::ctrl_cmd_t    ctl
);
    import pidd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctl         = '0;
        ctl.mul_sel = MUL_OFFSET;
        ctl.wrap_k  = cnt_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_CLEAR)
                    begin
                        ctl.clear = 1'b1;
                    end
                    else
                    begin
                        ctl.load   = 1'b1;
                        state_next = ST_MUL_OFF;
                    end
                end
            end
            ST_MUL_OFF:
            begin
                ctl.mul_sel = MUL_OFFSET;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                ctl.wr_err = 1'b1;
                if (sts.angle)
                begin
                    cnt_next   = STEP_W'(WRAP_STEPS - 1);
                    state_next = ST_WRAP;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_WRAP:
            begin
                ctl.wrap_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_WRAP_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_WRAP_DONE:
            begin
                ctl.wrap_done = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                ctl.wr_acc  = 1'b1;
                ctl.mul_sel = MUL_P;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                ctl.wr_p    = 1'b1;
                ctl.mul_sel = MUL_I;
                state_next  = ST_MUL_DN;
            end
            ST_MUL_DN:
            begin
                ctl.wr_i    = 1'b1;
                ctl.mul_sel = MUL_DNEW;
                state_next  = ST_MUL_DO;
            end
            ST_MUL_DO:
            begin
                ctl.wr_ba   = 1'b1;
                ctl.mul_sel = MUL_DOLD;
                state_next  = ST_BLEND;
            end
            ST_BLEND:
            begin
                ctl.wr_blend = 1'b1;
                state_next   = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                ctl.mul_sel = MUL_D;
                state_next  = ST_DTERM;
            end
            ST_DTERM:
            begin
                ctl.wr_d   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!sts.out_busy)
                begin
                    ctl.wr_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/pidd_dp.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative datapath
// Shared multiplier, error, wrap, accumulator, blend and result registers.
// ----------------------------------------------------------------------------
module pidd_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidd_pkg::cfg_t        cfg,
    input  pidd_pkg::ctrl_cmd_t   ctl,
    input  pidd_pkg::data_t       target,
    input  pidd_pkg::data_t       measured,
    input  pidd_pkg::data_t       target_offset,
    input  logic                  out_ready,
    output logic                  out_valid,
    output pidd_pkg::data_t       drive,
    output pidd_pkg::data_t       p_term,
    output pidd_pkg::data_t       i_term,
    output pidd_pkg::data_t       d_term,
    output pidd_pkg::dp_status_t  sts
);
    import pidd_pkg::*;

    localparam blend_t BLEND_ONE_V = BLEND_WIDTH'(BLEND_ONE);
    localparam data_t  HALF_D      = DATA_WIDTH'(HALF_TURN);

    data_t             target_reg, meas_reg, off_reg;
    prod_t             prod_reg, prod_next;
    data_t             err_reg, err_next;
    logic [WRAP_W-1:0] wrap_reg, wrap_next;
    data_t             acc_reg, acc_next;
    data_t             pm_reg, pm_next;
    data_t             pd_reg, pd_next;
    data_t             dnew_reg, dnew_next;
    data_t             p_reg, p_next;
    data_t             i_reg, i_next;
    data_t             ba_reg, ba_next;
    data_t             d_reg, d_next;
    logic              out_valid_reg, out_valid_next;
    data_t             drive_reg, p_out_reg, i_out_reg, d_out_reg;

    blend_t            kb;
    blend_t            kb_inv;
    data_t             mul_a;
    gain_t             mul_b;
    data_t             off_eff;
    wide_t             err_sum;
    logic [WRAP_W-1:0] wrap_sub;
    logic [WRAP_W-1:0] wrap_centered;
    logic signed [DATA_WIDTH:0] acc_sum;
    logic signed [DATA_WIDTH:0] lim_s;
    data_t             lim_d;
    logic              out_busy;

    assign kb     = (cfg.blend_factor > BLEND_ONE_V) ? BLEND_ONE_V : cfg.blend_factor;
    assign kb_inv = BLEND_ONE_V - kb;

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_OFFSET:
            begin
                mul_a = off_reg;
                mul_b = GAIN_WIDTH'(SCALE_003);
            end
            MUL_P:
            begin
                mul_a = err_reg;
                mul_b = cfg.gain_p;
            end
            MUL_I:
            begin
                mul_a = acc_reg;
                mul_b = cfg.gain_i;
            end
            MUL_DNEW:
            begin
                mul_a = dnew_reg;
                mul_b = GAIN_WIDTH'(kb);
            end
            MUL_DOLD:
            begin
                mul_a = pd_reg;
                mul_b = GAIN_WIDTH'(kb_inv);
            end
            default:
            begin
                mul_a = pd_reg;
                mul_b = cfg.gain_d;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, mul_b});

    assign off_eff = (cfg.loop_mode == MODE_POSITION) ? shift_sat(prod_reg, 1'b0) : off_reg;
    assign err_sum = ext_wide(target_reg) + ext_wide(off_eff) - ext_wide(meas_reg);

    assign wrap_sub      = FULL_WRAP << ctl.wrap_k;
    assign wrap_centered = wrap_reg - HALF_WRAP;

    assign acc_sum = {acc_reg[DATA_WIDTH-1], acc_reg} + {err_reg[DATA_WIDTH-1], err_reg};
    assign lim_s   = {2'b00, cfg.integral_limit};
    assign lim_d   = {1'b0, cfg.integral_limit};

    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        err_next       = err_reg;
        wrap_next      = wrap_reg;
        acc_next       = acc_reg;
        pm_next        = pm_reg;
        pd_next        = pd_reg;
        dnew_next      = dnew_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        ba_next        = ba_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (ctl.clear)
        begin
            acc_next = '0;
        end
        if (ctl.wr_err)
        begin
            err_next  = sat_wide(err_sum);
            wrap_next = WRAP_W'({{(WRAP_W-SUM_W){err_sum[SUM_W-1]}}, err_sum}) + WRAP_BIAS;
        end
        if (ctl.wrap_step && (wrap_reg >= wrap_sub))
        begin
            wrap_next = wrap_reg - wrap_sub;
        end
        if (ctl.wrap_done)
        begin
            err_next = wrap_centered[DATA_WIDTH-1:0];
        end
        if (ctl.wr_acc)
        begin
            if (acc_sum > lim_s)
            begin
                acc_next = lim_d;
            end
            else if (acc_sum < -lim_s)
            begin
                acc_next = -lim_d;
            end
            else
            begin
                acc_next = acc_sum[DATA_WIDTH-1:0];
            end
            dnew_next = sat_wide(ext_wide(pm_reg) - ext_wide(meas_reg));
            pm_next   = meas_reg;
        end
        if (ctl.wr_p)
        begin
            p_next = shift_sat(prod_reg, 1'b0);
        end
        if (ctl.wr_i)
        begin
            i_next = shift_sat(prod_reg, 1'b0);
        end
        if (ctl.wr_ba)
        begin
            ba_next = shift_sat(prod_reg, 1'b1);
        end
        if (ctl.wr_blend)
        begin
            pd_next = sat_wide(ext_wide(ba_reg) + ext_wide(shift_sat(prod_reg, 1'b1)));
        end
        if (ctl.wr_d)
        begin
            d_next = shift_sat(prod_reg, 1'b0);
        end
        if (ctl.wr_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pm_reg        <= '0;
            pd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pm_reg        <= pm_next;
            pd_reg        <= pd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            target_reg <= target;
            meas_reg   <= measured;
            off_reg    <= target_offset;
        end
        if (ctl.wr_out)
        begin
            drive_reg <= sat_wide(ext_wide(p_reg) + ext_wide(i_reg) + ext_wide(d_reg));
            p_out_reg <= p_reg;
            i_out_reg <= i_reg;
            d_out_reg <= d_reg;
        end
        prod_reg <= prod_next;
        err_reg  <= err_next;
        wrap_reg <= wrap_next;
        dnew_reg <= dnew_next;
        p_reg    <= p_next;
        i_reg    <= i_next;
        ba_reg   <= ba_next;
        d_reg    <= d_next;
    end

    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;
    assign p_term       = p_out_reg;
    assign i_term       = i_out_reg;
    assign d_term       = d_out_reg;
    assign sts.angle    = (cfg.loop_mode == MODE_ANGLE);
    assign sts.out_busy = out_busy;

    a_clear_zeroes_acc: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (acc_reg == '0))
        else $error("accumulator not cleared");

    a_acc_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_acc |=> ((acc_reg <= $past(lim_d)) && (acc_reg >= -$past(lim_d))))
        else $error("accumulator outside its limit");

    a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wrap_done |=> ((err_reg >= -HALF_D) && (err_reg < HALF_D)))
        else $error("wrapped error outside half turn");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_out |-> !out_busy)
        else $error("result written while previous beat is stalled");

endmodule

/* rtl/pid_incomplete_derivative_top.sv */
// ----------------------------------------------------------------------------
// PID controller with incomplete derivative, top level
// A step beat runs six products through one shared multiplier and, in angle
// mode, the ten iteration restoring loop that wraps the angle error; a new
// step beat is taken only once the previous result has been written out.
// A clear beat zeroes the integral accumulator and returns no result.
// Asynchronous active-low reset returns the control state, configuration,
// accumulator, filter and valid registers to reset values; others are not.
// ----------------------------------------------------------------------------
module pid_incomplete_derivative_top (
    input  logic                         clk,
    input  logic                         rst_n,
    pidd_in_if.sink                      step,
    pidd_out_if.source                   result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidd_pkg::APB_AW-1:0]  paddr,
    input  logic [pidd_pkg::APB_DW-1:0]  pwdata,
    output logic [pidd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import pidd_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  ctl;
    dp_status_t sts;

    pidd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step.valid),
        .in_cmd   (step.cmd),
        .in_ready (step.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pidd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .ctl           (ctl),
        .target        (step.target),
        .measured      (step.measured),
        .target_offset (step.target_offset),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .drive         (result.drive),
        .p_term        (result.p_term),
        .i_term        (result.i_term),
        .d_term        (result.d_term),
        .sts           (sts)
    );

endmodule

/* test/tb_pid_incomplete_derivative_top.sv */
// ----------------------------------------------------------------------------
// PID incomplete derivative testbench
// Drives step and clear beats into the controller under random idling on both
// channels and programs its registers over the APB port between phases. An
// in-bench fixed-point predictor computes each expected result and a checker
// compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_pid_incomplete_derivative_top;
    import pidd_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int IDLE_PERCENT    = 36;
    localparam int MAX_PRINTED     = 40;

    localparam logic [APB_DW-1:0] GAIN_ONE = 32'h0001_0000;
    localparam logic [APB_DW-1:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam data_t ONE_Q16 = 32'sh0001_0000;
    localparam data_t DEG_180 = data_t'(HALF_TURN);

    typedef struct {
        data_t drive;
        data_t p_term;
        data_t i_term;
        data_t d_term;
    } pid_terms_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pidd_in_if  step_if();
    pidd_out_if result_if();

    pid_incomplete_derivative_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gain_t  kp;
    gain_t  ki;
    gain_t  kd;
    gain_t  lim_cfg;
    blend_t kb_cfg;
    mode_t  mode_cfg;

    longint integ_acc;
    longint last_measured;
    longint last_rate;

    pid_terms_t pending_terms[$];

    int idle_pct        = IDLE_PERCENT;
    int mismatches      = 0;
    int steps_sent      = 0;
    int clears_sent     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint clamp_data(input longint x);
        if (x > longint'(DMAX))
        begin
            return longint'(DMAX);
        end
        if (x < longint'(DMIN))
        begin
            return longint'(DMIN);
        end
        return x;
    endfunction

    function automatic longint scale_floor(input longint a, input longint b, input int sh);
        longint prod;
        prod = a * b;
        return clamp_data(prod >>> sh);
    endfunction

    function automatic pid_terms_t predict_step(input data_t tgt, input data_t meas,
                                                input data_t off);
        pid_terms_t t;
        longint     trim;
        longint     err;
        longint     wrapped;
        longint     acc;
        longint     lim;
        longint     kb;
        longint     rate_new;
        longint     rate;
        longint     p;
        longint     i;
        longint     d;
        trim = longint'(off);
        if (mode_cfg == MODE_POSITION)
        begin
            trim = scale_floor(trim, SCALE_003, FRAC_BITS);
        end
        err = longint'(tgt) + trim - longint'(meas);
        if (mode_cfg == MODE_ANGLE)
        begin
            wrapped = (err + HALF_TURN) % FULL_TURN;
            if (wrapped < 0)
            begin
                wrapped += FULL_TURN;
            end
            err = wrapped - HALF_TURN;
        end
        err = clamp_data(err);
        p = scale_floor(err, longint'(kp), FRAC_BITS);

        lim = longint'(lim_cfg);
        acc = integ_acc + err;
        if (acc > lim)
        begin
            acc = lim;
        end
        if (acc < -lim)
        begin
            acc = -lim;
        end
        integ_acc = acc;
        i = scale_floor(acc, longint'(ki), FRAC_BITS);

        kb = (kb_cfg > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(kb_cfg);
        rate_new = clamp_data(last_measured - longint'(meas));
        rate = clamp_data(scale_floor(rate_new, kb, BLEND_SHIFT) +
                          scale_floor(last_rate, longint'(BLEND_ONE) - kb, BLEND_SHIFT));
        last_rate = rate;
        last_measured = longint'(meas);
        d = scale_floor(rate, longint'(kd), FRAC_BITS);

        t.drive  = data_t'(clamp_data(p + i + d));
        t.p_term = data_t'(p);
        t.i_term = data_t'(i);
        t.d_term = data_t'(d);
        return t;
    endfunction

    function automatic data_t pick_value();
        data_t v;
        int    deg;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                v = $urandom;
            end
            4, 5, 6:
            begin
                v = $urandom;
                v = v >>> $urandom_range(28, 4);
            end
            7:
            begin
                deg = $urandom_range(1440);
                deg -= 720;
                v = data_t'(deg) <<< FRAC_BITS;
            end
            8:
            begin
                case ($urandom_range(3))
                    0: v = DMAX;
                    1: v = DMIN;
                    2: v = DMAX - 1;
                    default: v = DMIN + 1;
                endcase
            end
            default:
            begin
                deg = $urandom_range(8);
                v = data_t'(deg - 4);
            end
        endcase
        return v;
    endfunction

    function automatic logic [APB_DW-1:0] pick_gain();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(GAIN_MAX);
            2, 3: return $urandom_range(4 * GAIN_ONE);
            4: return $urandom_range(4096);
            default: return $urandom_range(1) ? GAIN_MAX : '0;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] pick_blend();
        case ($urandom_range(4))
            0: return '0;
            1: return BLEND_ONE;
            2: return $urandom_range(BLEND_ONE);
            3: return $urandom_range(17'h1FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] pick_limit();
        case ($urandom_range(4))
            0: return '0;
            1: return $urandom_range(GAIN_ONE);
            2: return $urandom_range(GAIN_MAX);
            3: return GAIN_MAX;
            default: return $urandom_range(64 * GAIN_ONE);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input data_t got, input data_t want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("MISMATCH beat %0d %s: got %0d expected %0d",
                     results_checked, what, got, want);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAIN_P:    kp = gain_t'(value);
            REG_GAIN_I:    ki = gain_t'(value);
            REG_GAIN_D:    kd = gain_t'(value);
            REG_BLEND:     kb_cfg = blend_t'(value);
            REG_INT_LIMIT: lim_cfg = gain_t'(value);
            REG_LOOP_MODE: mode_cfg = mode_t'(value);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input logic [APB_DW-1:0] p, input logic [APB_DW-1:0] i,
                                input logic [APB_DW-1:0] d, input logic [APB_DW-1:0] kb,
                                input logic [APB_DW-1:0] lim, input logic [APB_DW-1:0] mode);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_BLEND, kb);
        write_reg(REG_INT_LIMIT, lim);
        write_reg(REG_LOOP_MODE, mode);
    endtask

    task automatic send_beat(input logic op, input data_t tgt, input data_t meas,
                             input data_t off);
        while ($urandom_range(99) < idle_pct)
        begin
            step_if.valid <= 1'b0;
            @(posedge clk);
        end
        step_if.valid         <= 1'b1;
        step_if.cmd           <= op;
        step_if.target        <= tgt;
        step_if.measured      <= meas;
        step_if.target_offset <= off;
        do @(posedge clk); while (!step_if.ready);
        if (op == CMD_CLEAR)
        begin
            integ_acc = 0;
            clears_sent++;
        end
        else
        begin
            pending_terms.push_back(predict_step(tgt, meas, off));
            steps_sent++;
        end
    endtask

    task automatic drain_results();
        step_if.valid <= 1'b0;
        while (pending_terms.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_beat(CMD_STEP, 32'sh0010_0000, 32'sh0004_0000, 32'sh0000_8000);
        send_beat(CMD_STEP, DMAX, DMIN, '0);
        drain_results();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_GAIN_P, GAIN_ONE);
        write_reg(REG_GAIN_I, GAIN_ONE);
        write_reg(REG_GAIN_D, GAIN_ONE);
        send_beat(CMD_STEP, DMAX, DMIN, DMAX);
        send_beat(CMD_STEP, DMIN, DMAX, DMIN);
        send_beat(CMD_STEP, '0, '0, DMAX);
        send_beat(CMD_STEP, '0, DMIN, DMIN);
        send_beat(CMD_CLEAR, DMAX, DMAX, DMAX);
        send_beat(CMD_STEP, ONE_Q16, '0, '0);
        drain_results();
    endtask

    task automatic test_loop_modes();
        write_reg(REG_LOOP_MODE, MODE_POSITION);
        send_beat(CMD_STEP, '0, '0, DMAX);
        send_beat(CMD_STEP, '0, '0, DMIN);
        send_beat(CMD_STEP, 32'sd100 <<< FRAC_BITS, 32'sd3 <<< FRAC_BITS,
                  32'sd1000 <<< FRAC_BITS);
        drain_results();
        write_reg(REG_LOOP_MODE, MODE_ANGLE);
        send_beat(CMD_STEP, DEG_180, '0, '0);
        send_beat(CMD_STEP, -DEG_180, '0, '0);
        send_beat(CMD_STEP, '0, DEG_180, '0);
        send_beat(CMD_STEP, DMAX, DMIN, '0);
        send_beat(CMD_STEP, 32'sd190 <<< FRAC_BITS, -(32'sd200 <<< FRAC_BITS),
                  32'sd5 <<< FRAC_BITS);
        drain_results();
        write_reg(REG_LOOP_MODE, 32'd3);
        send_beat(CMD_STEP, ONE_Q16, -ONE_Q16, ONE_Q16);
        drain_results();
    endtask

    task automatic test_blend_and_limit();
        write_reg(REG_LOOP_MODE, MODE_PLAIN);
        write_reg(REG_BLEND, '0);
        send_beat(CMD_STEP, ONE_Q16, 32'sd7 <<< FRAC_BITS, '0);
        drain_results();
        write_reg(REG_BLEND, 32'h0001_FFFF);
        send_beat(CMD_STEP, ONE_Q16, -(32'sd9 <<< FRAC_BITS), '0);
        drain_results();
        write_reg(REG_BLEND, BLEND_ONE);
        send_beat(CMD_STEP, '0, DMAX, '0);
        drain_results();
        apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, 32'd32768, '0, MODE_PLAIN);
        send_beat(CMD_STEP, DMAX, '0, '0);
        send_beat(CMD_STEP, 32'sd1, '0, '0);
        send_beat(CMD_CLEAR, '0, '0, '0);
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, BLEND_ONE, GAIN_MAX, MODE_PLAIN);
                1: apply_config(GAIN_ONE, GAIN_ONE, GAIN_ONE, '0, '0, MODE_ANGLE);
                2: apply_config(GAIN_ONE, GAIN_ONE / 4, 2 * GAIN_ONE, pick_blend(),
                                $urandom_range(16 * GAIN_ONE), MODE_POSITION);
                3: apply_config(pick_gain(), pick_gain(), pick_gain(), 32'h0001_FFFF,
                                pick_limit(), 32'd3);
                default: apply_config(pick_gain(), pick_gain(), pick_gain(), pick_blend(),
                                      pick_limit(), $urandom_range(3));
            endcase
            idle_pct = (ph == 5) ? 0 : IDLE_PERCENT;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    send_beat(CMD_CLEAR, pick_value(), pick_value(), pick_value());
                end
                else
                begin
                    send_beat(CMD_STEP, pick_value(), pick_value(), pick_value());
                end
            end
            drain_results();
        end
        idle_pct = IDLE_PERCENT;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        pid_terms_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_terms.size() == 0)
            begin
                report_mismatch("unexpected drive", result_if.drive, '0);
            end
            else
            begin
                want = pending_terms.pop_front();
                if (result_if.drive !== want.drive)
                begin
                    report_mismatch("drive", result_if.drive, want.drive);
                end
                if (result_if.p_term !== want.p_term)
                begin
                    report_mismatch("p_term", result_if.p_term, want.p_term);
                end
                if (result_if.i_term !== want.i_term)
                begin
                    report_mismatch("i_term", result_if.i_term, want.i_term);
                end
                if (result_if.d_term !== want.d_term)
                begin
                    report_mismatch("d_term", result_if.d_term, want.d_term);
                end
            end
            results_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (step_if.valid && step_if.ready) ||
            (result_if.valid && result_if.ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_terms.size());
            $display("pid_incomplete_derivative_top verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        step_if.valid         = 1'b0;
        step_if.cmd           = CMD_STEP;
        step_if.target        = '0;
        step_if.measured      = '0;
        step_if.target_offset = '0;

        kp            = '0;
        ki            = '0;
        kd            = '0;
        kb_cfg        = blend_t'(32768);
        lim_cfg       = gain_t'(GAIN_MAX);
        mode_cfg      = MODE_PLAIN;
        integ_acc     = 0;
        last_measured = 0;
        last_rate     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_loop_modes();
        test_blend_and_limit();
        test_random_phases();

        drain_results();
        $display("Sent %0d step beats and %0d clear beats; checked %0d result beats.",
                 steps_sent, clears_sent, results_checked);
        $display("Used %0d register writes over all loop modes, blend and limit extremes.",
                 reg_writes);
        if (mismatches == 0)
        begin
            $display("pid_incomplete_derivative_top verification clean");
        end
        else
        begin
            $display("pid_incomplete_derivative_top verification failed");
        end
        $finish;
    end

endmodule
